// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/gbos_pkg.sv =====
// ---------------------------------------------------------------------------
// gbos_pkg
// Shared types and constants of the greedy box overlap suppression block.
// ---------------------------------------------------------------------------
package gbos_pkg;

   localparam int KEPT_DEPTH = 64;
   localparam int SLOT_W     = $clog2(KEPT_DEPTH);
   localparam int COUNT_W    = $clog2(KEPT_DEPTH + 1);
   localparam int COORD_W    = 16;
   localparam int THR_W      = 9;
   localparam logic [THR_W-1:0] THR_RESET = 9'd128;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } box_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== src/greedy_box_overlap_suppression.sv =====
// ---------------------------------------------------------------------------
// greedy_box_overlap_suppression
// Greedy class-agnostic suppression of candidate boxes by IoU threshold.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate box per transfer (valid/ready); rsp_* returns
//   one verdict per box (kept, slot, store_overflow, kept_total).
//   csr_write_enable/csr_write_data set the Q1.8 IoU threshold; write only
//   while no box is in flight.
//   A box is tested against the N boxes stored for the current frame, one
//   stored box read from the slot memory per cycle into a four-stage IoU
//   pipeline. The scan stops reading stored boxes once one of them suppresses
//   the box. The slot memory read rate sets the cost per stored box.
//   The next box is taken once the verdict sits in the output register;
//   if the receiver stalls, the block holds the next verdict until the
//   output register frees.
//   Reset empties the store, sets the threshold to 128 and drops any box in
//   flight. The slot memory itself is not cleared; slots past the count are
//   never read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_box_overlap_suppression
   import gbos_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_start_frame,
   input  logic signed [COORD_W-1:0] req_left_edge,
   input  logic signed [COORD_W-1:0] req_top_edge,
   input  logic signed [COORD_W-1:0] req_right_edge,
   input  logic signed [COORD_W-1:0] req_bottom_edge,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kept,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic                      rsp_store_overflow,
   output logic [COUNT_W-1:0]        rsp_kept_total,
   input  logic                      csr_write_enable,
   input  logic [THR_W-1:0]          csr_write_data
);

   box_type mem [KEPT_DEPTH];

   state_type           state_ff, state_in;
   box_type             box_ff;
   box_type             rd_box_ff;
   tag_type             rd_tag_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  issue_idx_ff;
   logic [THR_W-1:0]    thr_ff;
   logic                hit_found_ff;
   logic [SLOT_W-1:0]   hit_slot_ff;

   logic                rsp_valid_ff;
   logic                rsp_kept_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_ovf_ff;
   logic [COUNT_W-1:0]  rsp_total_ff;

   logic    req_fire;
   logic    can_issue;
   logic    scan_done;
   logic    fin_fire;
   logic    full;
   logic    keep;
   logic    store;
   tag_type issue_tag;
   tag_type core_tag;
   logic    core_hit;
   logic    core_busy;

   assign full = (count_ff == COUNT_W'(KEPT_DEPTH));
   assign keep = !hit_found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid)  state_in = ST_SCAN;
         ST_SCAN:   if (scan_done)  state_in = ST_FINISH;
         ST_FINISH: if (fin_fire)   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      can_issue = 1'b0;
      scan_done = 1'b0;
      fin_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            can_issue = !hit_found_ff && (issue_idx_ff < count_ff);
            scan_done = !can_issue && !rd_tag_ff.valid && !core_busy;
         end
         ST_FINISH: begin
            fin_fire = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_fire        = req_valid && req_ready;
   assign store           = fin_fire && keep && !full;
   assign issue_tag.valid = can_issue;
   assign issue_tag.slot  = issue_idx_ff[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   // slot memory: read one stored box per cycle, write back a survivor
   always_ff @(posedge clock) begin
      if (store) begin
         mem[count_ff[SLOT_W-1:0]] <= box_ff;
      end
      if (can_issue) begin
         rd_box_ff <= mem[issue_idx_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff <= issue_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff.left   <= req_left_edge;
         box_ff.top    <= req_top_edge;
         box_ff.right  <= req_right_edge;
         box_ff.bottom <= req_bottom_edge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_idx_ff <= '0;
         hit_found_ff <= 1'b0;
         hit_slot_ff  <= '0;
      end else begin
         if (req_fire) begin
            issue_idx_ff <= '0;
            hit_found_ff <= 1'b0;
            if (req_start_frame) begin
               count_ff <= '0;
            end
         end
         if (can_issue) begin
            issue_idx_ff <= issue_idx_ff + 1'b1;
         end
         // first hit out of the pipe is the lowest slot; drop later ones
         if (state_ff == ST_SCAN && core_hit && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_slot_ff  <= core_tag.slot;
         end
         if (store) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         rsp_kept_ff  <= keep;
         rsp_ovf_ff   <= keep && full;
         rsp_total_ff <= store ? (count_ff + 1'b1) : count_ff;
         if (!keep) begin
            rsp_slot_ff <= hit_slot_ff;
         end else if (full) begin
            rsp_slot_ff <= '0;
         end else begin
            rsp_slot_ff <= count_ff[SLOT_W-1:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kept           = rsp_kept_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_store_overflow = rsp_ovf_ff;
   assign rsp_kept_total     = rsp_total_ff;

   gbos_overlap u_overlap (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (rd_tag_ff),
      .kept_box  (rd_box_ff),
      .new_box   (box_ff),
      .threshold (thr_ff),
      .tag_out   (core_tag),
      .hit       (core_hit),
      .busy      (core_busy)
   );

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(KEPT_DEPTH))
   `ASSERT_IMPLIES(a_issue_below_count, clock, reset, can_issue, issue_idx_ff < count_ff)
   `ASSERT_IMPLIES(a_hit_below_count, clock, reset, hit_found_ff && state_ff != ST_IDLE, {1'b0, hit_slot_ff} < count_ff)
   `ASSERT_NEXT(a_store_grows, clock, reset, store, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== src/gbos_overlap.sv =====
// ---------------------------------------------------------------------------
// gbos_overlap
// Pipelined IoU test of one stored box against the candidate box per cycle.
// ---------------------------------------------------------------------------
module gbos_overlap
   import gbos_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  tag_type          tag_in,
   input  box_type          kept_box,
   input  box_type          new_box,
   input  logic [THR_W-1:0] threshold,
   output tag_type          tag_out,
   output logic             hit,
   output logic             busy
);

   // candidate area, held steady while the scan runs
   logic signed [COORD_W:0]     nw;
   logic signed [COORD_W:0]     nh;
   logic signed [2*COORD_W+1:0] area_n_ff;

   // intersection and kept-box extents
   logic signed [COORD_W-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
   logic signed [COORD_W:0]   iw_d, ih_d;
   logic [COORD_W-1:0]        iw_in, ih_in;
   logic [COORD_W-1:0]        iw_ff, ih_ff;
   logic signed [COORD_W:0]   aw_ff, ah_ff;
   tag_type                   tag2_ff;

   logic [2*COORD_W-1:0]        inter3_ff;
   logic signed [2*COORD_W+1:0] area_a_ff;
   tag_type                     tag3_ff;

   logic signed [2*COORD_W+3:0] uni_ff;
   logic [2*COORD_W-1:0]        inter4_ff;
   tag_type                     tag4_ff;

   logic signed [2*COORD_W+THR_W+4:0] prod_ff;
   logic [2*COORD_W+7:0]              inter_sh_ff;
   logic                              uni_pos_ff;
   tag_type                           tag5_ff;

   assign nw = {new_box.right[COORD_W-1], new_box.right} - {new_box.left[COORD_W-1], new_box.left};
   assign nh = {new_box.bottom[COORD_W-1], new_box.bottom}
             - {new_box.top[COORD_W-1], new_box.top};

   always_ff @(posedge clock) begin
      area_n_ff <= nw * nh;
   end

   always_comb begin
      ix_lo = (kept_box.left > new_box.left)     ? kept_box.left   : new_box.left;
      ix_hi = (kept_box.right < new_box.right)   ? kept_box.right  : new_box.right;
      iy_lo = (kept_box.top > new_box.top)       ? kept_box.top    : new_box.top;
      iy_hi = (kept_box.bottom < new_box.bottom) ? kept_box.bottom : new_box.bottom;
      iw_d  = {ix_hi[COORD_W-1], ix_hi} - {ix_lo[COORD_W-1], ix_lo};
      ih_d  = {iy_hi[COORD_W-1], iy_hi} - {iy_lo[COORD_W-1], iy_lo};
      iw_in = iw_d[COORD_W] ? '0 : iw_d[COORD_W-1:0];
      ih_in = ih_d[COORD_W] ? '0 : ih_d[COORD_W-1:0];
   end

   // payload stages
   always_ff @(posedge clock) begin
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      aw_ff <= {kept_box.right[COORD_W-1], kept_box.right}
             - {kept_box.left[COORD_W-1], kept_box.left};
      ah_ff <= {kept_box.bottom[COORD_W-1], kept_box.bottom}
             - {kept_box.top[COORD_W-1], kept_box.top};

      inter3_ff <= iw_ff * ih_ff;
      area_a_ff <= aw_ff * ah_ff;

      uni_ff    <= $signed({{2{area_a_ff[2*COORD_W+1]}}, area_a_ff})
                 + $signed({{2{area_n_ff[2*COORD_W+1]}}, area_n_ff})
                 - $signed({4'b0, inter3_ff});
      inter4_ff <= inter3_ff;

      prod_ff     <= $signed({1'b0, threshold}) * uni_ff;
      inter_sh_ff <= {inter4_ff, 8'b0};
      uni_pos_ff  <= (uni_ff > 0);
   end

   // stage valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag2_ff <= tag_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   assign hit = tag5_ff.valid && uni_pos_ff
             && ($signed({7'b0, inter_sh_ff}) > $signed({prod_ff[2*COORD_W+THR_W+4], prod_ff}));
   assign tag_out = tag5_ff;
   assign busy    = tag2_ff.valid | tag3_ff.valid | tag4_ff.valid | tag5_ff.valid;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks greedy box overlap suppression against an in-bench tracker of the
// kept store. Directed boxes hit the corners, inverted and empty boxes, ties
// between kept boxes and the threshold extremes. Random frames of clustered,
// tiled and raw boxes follow, under three idle patterns and a long receiver
// hold-off, with the threshold rewritten while the block is idle.
// ---------------------------------------------------------------------------
module testbench;
   import gbos_pkg::*;

   typedef struct {
      logic               kept;
      logic [SLOT_W-1:0]  slot;
      logic               overflow;
      logic [COUNT_W-1:0] total;
   } verdict_type;

   class suppression_tracker;
      box_type     kept_boxes [KEPT_DEPTH];
      int          kept_count;
      int          threshold;
      verdict_type pending_verdicts [$];
      int          mismatches;

      function new();
         kept_count = 0;
         threshold  = THR_RESET;
         mismatches = 0;
      endfunction

      function void set_threshold(int value);
         threshold = value;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      function bit box_overlaps(box_type a, box_type n);
         longint a_l, a_t, a_r, a_b, n_l, n_t, n_r, n_b;
         longint iw, ih, inter, area_a, area_n, uni;
         a_l = $signed(a.left);
         a_t = $signed(a.top);
         a_r = $signed(a.right);
         a_b = $signed(a.bottom);
         n_l = $signed(n.left);
         n_t = $signed(n.top);
         n_r = $signed(n.right);
         n_b = $signed(n.bottom);
         iw = ((a_r < n_r) ? a_r : n_r) - ((a_l > n_l) ? a_l : n_l);
         ih = ((a_b < n_b) ? a_b : n_b) - ((a_t > n_t) ? a_t : n_t);
         if (iw < 0) iw = 0;
         if (ih < 0) ih = 0;
         inter  = iw * ih;
         area_a = (a_r - a_l) * (a_b - a_t);
         area_n = (n_r - n_l) * (n_b - n_t);
         uni    = area_a + area_n - inter;
         if (uni <= 0) return 1'b0;
         return (inter * 256) > (longint'(threshold) * uni);
      endfunction

      function void note_box(logic start, box_type nb);
         verdict_type v;
         int i;
         if (start) kept_count = 0;
         v.kept     = 1'b1;
         v.slot     = '0;
         v.overflow = 1'b0;
         for (i = 0; i < kept_count; i++) begin
            if (box_overlaps(kept_boxes[i], nb)) begin
               v.kept = 1'b0;
               v.slot = i[SLOT_W-1:0];
               break;
            end
         end
         if (v.kept) begin
            if (kept_count < KEPT_DEPTH) begin
               v.slot = kept_count[SLOT_W-1:0];
               kept_boxes[kept_count] = nb;
               kept_count++;
            end else begin
               v.overflow = 1'b1;
            end
         end
         v.total = kept_count[COUNT_W-1:0];
         pending_verdicts.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected verdict: kept=%0d slot=%0d overflow=%0d total=%0d",
                        got.kept, got.slot, got.overflow, got.total);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.kept !== want.kept || got.slot !== want.slot ||
             got.overflow !== want.overflow || got.total !== want.total) begin
            mismatches++;
            if (mismatches <= 10)
               $display("verdict mismatch: expected kept=%0d slot=%0d overflow=%0d total=%0d, %s",
                        want.kept, want.slot, want.overflow, want.total,
                        $sformatf("got kept=%0d slot=%0d overflow=%0d total=%0d",
                                  got.kept, got.slot, got.overflow, got.total));
         end
      endfunction
   endclass

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_ready;
   logic                      req_start_frame    = 1'b0;
   logic signed [COORD_W-1:0] req_left_edge      = '0;
   logic signed [COORD_W-1:0] req_top_edge       = '0;
   logic signed [COORD_W-1:0] req_right_edge     = '0;
   logic signed [COORD_W-1:0] req_bottom_edge    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready          = 1'b0;
   logic                      rsp_kept;
   logic [SLOT_W-1:0]         rsp_slot;
   logic                      rsp_store_overflow;
   logic [COUNT_W-1:0]        rsp_kept_total;
   logic                      csr_write_enable   = 1'b0;
   logic [THR_W-1:0]          csr_write_data     = '0;

   suppression_tracker tracker = new();

   int      send_idle  = 13;
   int      recv_idle  = 49;
   int      hold_asks  = 0;
   int      hold_taken = 0;
   int      hold_left  = 0;
   int      frame_cx;
   int      frame_cy;
   box_type grid_store [128];

   greedy_box_overlap_suppression u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_frame    (req_start_frame),
      .req_left_edge      (req_left_edge),
      .req_top_edge       (req_top_edge),
      .req_right_edge     (req_right_edge),
      .req_bottom_edge    (req_bottom_edge),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kept           (rsp_kept),
      .rsp_slot           (rsp_slot),
      .rsp_store_overflow (rsp_store_overflow),
      .rsp_kept_total     (rsp_kept_total),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = 600;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : sample_verdict
      verdict_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kept     = rsp_kept;
         got.slot     = rsp_slot;
         got.overflow = rsp_store_overflow;
         got.total    = rsp_kept_total;
         tracker.check_verdict(got);
      end
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[COORD_W-1:0];
   endfunction

   function automatic box_type make_box(int l, int t, int r, int b);
      box_type bx;
      bx.left   = clamp_coord(l);
      bx.top    = clamp_coord(t);
      bx.right  = clamp_coord(r);
      bx.bottom = clamp_coord(b);
      return bx;
   endfunction

   function automatic box_type wild_box();
      box_type bx;
      bx = {$urandom(), $urandom()};
      return bx;
   endfunction

   function automatic box_type cluster_box();
      int l, t, w, h;
      l = frame_cx + int'($urandom_range(800)) - 400;
      t = frame_cy + int'($urandom_range(800)) - 400;
      w = int'($urandom_range(900));
      h = int'($urandom_range(900));
      if ($urandom_range(19) == 0) return make_box(l + w, t + h, l, t);
      return make_box(l, t, l + w, t + h);
   endfunction

   // tiles are disjoint; some repeat an earlier tile of the frame
   function automatic box_type grid_box(int k);
      int l, t;
      if (k > 0 && $urandom_range(9) == 0) begin
         grid_store[k] = grid_store[$urandom_range(k - 1)];
         return grid_store[k];
      end
      l = -30000 + (k % 16) * 3000 + int'($urandom_range(200));
      t = -30000 + (k / 16) * 3000 + int'($urandom_range(200));
      grid_store[k] = make_box(l, t, l + int'($urandom_range(100, 2500)),
                               t + int'($urandom_range(100, 2500)));
      return grid_store[k];
   endfunction

   task automatic send_box(logic start, box_type bx);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_start_frame <= start;
      req_left_edge   <= bx.left;
      req_top_edge    <= bx.top;
      req_right_edge  <= bx.right;
      req_bottom_edge <= bx.bottom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_box(start, bx);
      @(negedge clock);
   endtask

   task automatic send_corners(logic start, int l, int t, int r, int b);
      send_box(start, make_box(l, t, r, b));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic program_threshold(int value);
      wait_drained();
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[THR_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_threshold(value);
   endtask

   task automatic run_segment(int count);
      int      sent, frame_len, kind, pick, i;
      logic    start;
      box_type bx;
      sent = 0;
      while (sent < count) begin
         pick      = $urandom_range(99);
         kind      = (pick < 70) ? 0 : (pick < 85) ? 1 : 2;
         frame_len = (kind == 1) ? $urandom_range(66, 90) :
                     (kind == 2) ? $urandom_range(2, 20) : $urandom_range(3, 40);
         frame_cx  = int'($urandom_range(60000)) - 30000;
         frame_cy  = int'($urandom_range(60000)) - 30000;
         for (i = 0; i < frame_len && sent < count; i++) begin
            start = (i == 0) || ($urandom_range(99) == 0);
            case (kind)
               0: bx = ($urandom_range(9) == 0) ? wild_box() : cluster_box();
               1: bx = grid_box(i);
               default: bx = wild_box();
            endcase
            send_box(start, bx);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset threshold: duplicates, partial overlap, lowest slot wins
      send_corners(1'b1, 0, 0, 160, 160);
      send_corners(1'b0, 0, 0, 160, 160);
      send_corners(1'b0, 80, 0, 240, 160);
      send_corners(1'b0, 40, 0, 200, 160);
      // inverted and empty boxes
      send_corners(1'b0, 200, 200, 100, 100);
      send_corners(1'b0, 300, 0, 200, 100);
      send_corners(1'b0, 500, 500, 500, 500);
      send_corners(1'b0, 500, 500, 500, 500);
      // coordinate extremes
      send_corners(1'b0, -32768, -32768, 32767, 32767);
      send_corners(1'b0, -32768, -32768, 32767, 32767);
      send_corners(1'b0, 32767, 32767, -32768, -32768);
      send_corners(1'b0, -32768, -32768, -32768, -32768);
      send_corners(1'b1, -32768, 0, 32767, 16);
      send_corners(1'b0, 0, -32768, 16, 32767);

      program_threshold(0);
      send_corners(1'b1, 0, 0, 16, 16);
      send_corners(1'b0, 15, 15, 100, 100);
      send_corners(1'b0, 16, 16, 100, 100);

      program_threshold(256);
      send_corners(1'b0, 0, 0, 16, 16);
      send_corners(1'b0, 16, 16, 100, 100);

      program_threshold($urandom_range(40, 220));
      run_segment(255);
      program_threshold(511);
      run_segment(255);

      wait_drained();
      send_idle = 49;
      recv_idle = 13;
      program_threshold($urandom_range(40, 220));
      run_segment(255);
      program_threshold(0);
      run_segment(255);

      wait_drained();
      send_idle = 0;
      recv_idle = 0;
      program_threshold(256);
      hold_asks = hold_asks + 1;
      run_segment(255);
      program_threshold($urandom_range(1, 255));
      hold_asks = hold_asks + 1;
      run_segment(255);

      wait_drained();
      repeat (80) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
